// ===== rtl/ltd_pkg.sv =====
// ----------------------------------------------------------------------------
// ltd_pkg
// shared types, constants and register codes for the line track error block
// ----------------------------------------------------------------------------
package ltd_pkg;

    // sensor count default and weighted sensor count
    localparam int NUM_SENSORS  = 4;
    localparam int NUM_WEIGHTS  = 4;

    // field widths
    localparam int W_WIDTH      = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;
    localparam int SUM_WIDTH    = 10;
    localparam int FRAC_BITS    = 8;
    localparam int ERR_WIDTH    = 16;
    localparam int CNT_WIDTH    = 8;

    // divider: magnitude of sum * 256 fits in 18 bits
    localparam int DIV_WIDTH    = SUM_WIDTH + FRAC_BITS;
    localparam int DIV_BPS      = 3;
    localparam int DIV_ITERS    = DIV_WIDTH / DIV_BPS;

    // register reset values
    localparam logic signed [W_WIDTH-1:0] RST_WEIGHT_ZERO  = 8'sd40;
    localparam logic signed [W_WIDTH-1:0] RST_WEIGHT_ONE   = 8'sd8;
    localparam logic signed [W_WIDTH-1:0] RST_WEIGHT_TWO   = -8'sd8;
    localparam logic signed [W_WIDTH-1:0] RST_WEIGHT_THREE = -8'sd40;
    localparam logic [CNT_WIDTH-1:0]      RST_LOST_LIMIT   = 8'd4;
    localparam logic [CNT_WIDTH-1:0]      RST_CONFIRM      = 8'd20;
    localparam logic                      RST_LAP_MODE     = 1'b0;
    localparam logic [CNT_WIDTH-1:0]      RST_LAP_TARGET   = 8'd4;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT_ZERO   = 3'd0,
        CFG_WEIGHT_ONE    = 3'd1,
        CFG_WEIGHT_TWO    = 3'd2,
        CFG_WEIGHT_THREE  = 3'd3,
        CFG_LOST_LIMIT    = 3'd4,
        CFG_CONFIRM_COUNT = 3'd5,
        CFG_LAP_MODE      = 3'd6,
        CFG_LAP_TARGET    = 3'd7
    } t_ltd_cfg;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_COMMIT
    } t_ltd_state;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic step;
        logic commit;
    } t_ltd_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_ltd_sts;

endpackage

// ===== rtl/ltd_in_if.sv =====
// ----------------------------------------------------------------------------
// ltd_in_if
// input channel: one beat of line sensor bits
// ----------------------------------------------------------------------------
interface ltd_in_if #(
    parameter int NUM_SENSORS = ltd_pkg::NUM_SENSORS
);
    logic                   valid;
    logic                   ready;
    logic [NUM_SENSORS-1:0] sensor_bits;

    modport source (output valid, output sensor_bits, input ready);
    modport sink   (input valid, input sensor_bits, output ready);
endinterface

// ===== rtl/ltd_out_if.sv =====
// ----------------------------------------------------------------------------
// ltd_out_if
// result channel: track error, line flags and lap status
// ----------------------------------------------------------------------------
interface ltd_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ltd_pkg::ERR_WIDTH-1:0]  error_q8;
    logic                                  has_line;
    logic                                  confirmed_line;
    logic                                  confirm_flip;
    logic [ltd_pkg::CNT_WIDTH-1:0]         lap_count;
    logic                                  lap_done;

    modport source (output valid, output error_q8, output has_line,
                    output confirmed_line, output confirm_flip,
                    output lap_count, output lap_done, input ready);
    modport sink   (input valid, input error_q8, input has_line,
                    input confirmed_line, input confirm_flip,
                    input lap_count, input lap_done, output ready);
endinterface

// ===== rtl/ltd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ltd_ctrl
// sequencer: accept, divider steps, commit into the result register
// ----------------------------------------------------------------------------
module ltd_ctrl #(
    parameter int DIV_ITERS = ltd_pkg::DIV_ITERS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ltd_pkg::t_ltd_sts i_sts,
    output ltd_pkg::t_ltd_cmd o_cmd
);

    localparam int SCW = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;
    localparam logic [SCW-1:0] LAST_STEP = SCW'(DIV_ITERS - 1);

    ltd_pkg::t_ltd_state r_state, n_state;
    logic [SCW-1:0]      r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ltd_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            ltd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_step      = '0;
                    n_state     = ltd_pkg::ST_DIV;
                end
            end
            ltd_pkg::ST_DIV: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + SCW'(1);
                if (r_step == LAST_STEP) begin
                    n_state = ltd_pkg::ST_COMMIT;
                end
            end
            ltd_pkg::ST_COMMIT: begin
                // hold here while the previous result is still waiting
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ltd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ltd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ltd_div.sv =====
// ----------------------------------------------------------------------------
// ltd_div
// unsigned restoring divider, BPS quotient bits per step
// ----------------------------------------------------------------------------
module ltd_div #(
    parameter int DW  = ltd_pkg::DIV_WIDTH,
    parameter int VW  = 4,
    parameter int BPS = ltd_pkg::DIV_BPS
) (
    input  logic          i_clk,
    input  logic          i_start,
    input  logic          i_step,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic [DW-1:0] o_quotient
);

    logic [DW-1:0] r_num, n_num;
    logic [VW-1:0] r_rem, n_rem;
    logic [VW-1:0] r_den;
    logic [VW:0]   w_trial;

    always_comb begin
        n_num   = r_num;
        n_rem   = r_rem;
        w_trial = '0;
        for (int k = 0; k < BPS; k++) begin
            w_trial = {n_rem, n_num[DW-1]};
            if (w_trial >= {1'b0, r_den}) begin
                w_trial = w_trial - {1'b0, r_den};
                n_num   = {n_num[DW-2:0], 1'b1};
            end else begin
                n_num   = {n_num[DW-2:0], 1'b0};
            end
            n_rem = w_trial[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (i_step) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_num;

endmodule

// ===== rtl/ltd_dp.sv =====
// ----------------------------------------------------------------------------
// ltd_dp
// datapath: config registers, weighted sum, divider, tick state, result reg
// ----------------------------------------------------------------------------
module ltd_dp #(
    parameter int NUM_SENSORS = ltd_pkg::NUM_SENSORS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ltd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ltd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [NUM_SENSORS-1:0]               i_sensor_bits,
    input  ltd_pkg::t_ltd_cmd                    i_cmd,
    output ltd_pkg::t_ltd_sts                    o_sts,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [ltd_pkg::ERR_WIDTH-1:0] o_error_q8,
    output logic                                 o_has_line,
    output logic                                 o_confirmed_line,
    output logic                                 o_confirm_flip,
    output logic [ltd_pkg::CNT_WIDTH-1:0]        o_lap_count,
    output logic                                 o_lap_done
);

    localparam int CW  = $clog2(NUM_SENSORS + 1);
    localparam int NW  = (NUM_SENSORS < ltd_pkg::NUM_WEIGHTS) ?
                         NUM_SENSORS : ltd_pkg::NUM_WEIGHTS;
    localparam int SW  = ltd_pkg::SUM_WIDTH;
    localparam int DW  = ltd_pkg::DIV_WIDTH;
    localparam int EW  = ltd_pkg::ERR_WIDTH;
    localparam int NCW = ltd_pkg::CNT_WIDTH;

    // config registers
    logic signed [ltd_pkg::W_WIDTH-1:0] r_weight [ltd_pkg::NUM_WEIGHTS];
    logic [NCW-1:0] r_lost_limit;
    logic [NCW-1:0] r_confirm_count;
    logic           r_lap_mode;
    logic [NCW-1:0] r_lap_target;

    // per item working registers
    logic           r_line;
    logic           r_neg;

    // tick state
    logic signed [EW-1:0] r_held_error, n_held_error;
    logic [NCW-1:0]       r_lost_ticks, n_lost_ticks;
    logic                 r_confirmed,  n_confirmed;
    logic [NCW-1:0]       r_steady,     n_steady;
    logic [NCW-1:0]       r_laps,       n_laps;

    // result register
    logic                 r_out_valid;
    logic signed [EW-1:0] r_error_q8,  n_error_q8;
    logic                 r_has_line;
    logic                 r_conf_line;
    logic                 r_flip,      n_flip;
    logic [NCW-1:0]       r_lap_count;
    logic                 r_lap_done,  n_lap_done;

    logic signed [SW-1:0] w_sum;
    logic [CW-1:0]        w_count;
    logic [SW-1:0]        w_mag;
    logic [DW-1:0]        w_quo;
    logic signed [EW-1:0] w_err;
    logic [NCW-1:0]       w_steady_inc;
    logic [NCW-1:0]       w_laps_after;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight[0]     <= ltd_pkg::RST_WEIGHT_ZERO;
            r_weight[1]     <= ltd_pkg::RST_WEIGHT_ONE;
            r_weight[2]     <= ltd_pkg::RST_WEIGHT_TWO;
            r_weight[3]     <= ltd_pkg::RST_WEIGHT_THREE;
            r_lost_limit    <= ltd_pkg::RST_LOST_LIMIT;
            r_confirm_count <= ltd_pkg::RST_CONFIRM;
            r_lap_mode      <= ltd_pkg::RST_LAP_MODE;
            r_lap_target    <= ltd_pkg::RST_LAP_TARGET;
        end else if (i_cfg_we) begin
            case (ltd_pkg::t_ltd_cfg'(i_cfg_idx))
                ltd_pkg::CFG_WEIGHT_ZERO:   r_weight[0]     <= i_cfg_data;
                ltd_pkg::CFG_WEIGHT_ONE:    r_weight[1]     <= i_cfg_data;
                ltd_pkg::CFG_WEIGHT_TWO:    r_weight[2]     <= i_cfg_data;
                ltd_pkg::CFG_WEIGHT_THREE:  r_weight[3]     <= i_cfg_data;
                ltd_pkg::CFG_LOST_LIMIT:    r_lost_limit    <= i_cfg_data;
                ltd_pkg::CFG_CONFIRM_COUNT: r_confirm_count <= i_cfg_data;
                ltd_pkg::CFG_LAP_MODE:      r_lap_mode      <= i_cfg_data[0];
                ltd_pkg::CFG_LAP_TARGET:    r_lap_target    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // weighted sum and active count of the incoming beat
    always_comb begin
        w_sum   = '0;
        w_count = '0;
        for (int i = 0; i < NW; i++) begin
            if (i_sensor_bits[i]) begin
                w_sum = w_sum + SW'(r_weight[i]);
            end
        end
        for (int i = 0; i < NUM_SENSORS; i++) begin
            w_count = w_count + CW'(i_sensor_bits[i]);
        end
        w_mag = w_sum[SW-1] ? SW'(-w_sum) : SW'(w_sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_line <= (w_count != '0);
            r_neg  <= w_sum[SW-1];
        end
    end

    ltd_div #(
        .DW  (DW),
        .VW  (CW),
        .BPS (ltd_pkg::DIV_BPS)
    ) u_div (
        .i_clk      (i_clk),
        .i_start    (i_cmd.start),
        .i_step     (i_cmd.step),
        .i_dividend ({w_mag, {ltd_pkg::FRAC_BITS{1'b0}}}),
        .i_divisor  (w_count),
        .o_quotient (w_quo)
    );

    // truncation toward zero: divide the magnitude, then restore the sign
    assign w_err        = r_neg ? EW'(-w_quo) : EW'(w_quo);
    assign w_steady_inc = r_steady + NCW'(1);

    // tick state update
    always_comb begin
        n_held_error = r_held_error;
        n_lost_ticks = r_lost_ticks;
        n_confirmed  = r_confirmed;
        n_steady     = r_steady;
        n_laps       = r_laps;
        n_flip       = 1'b0;
        n_lap_done   = 1'b0;
        n_error_q8   = '0;

        if (r_line) begin
            n_lost_ticks = '0;
            n_held_error = w_err;
            n_error_q8   = w_err;
        end else if (r_lost_ticks < r_lost_limit) begin
            n_lost_ticks = r_lost_ticks + NCW'(1);
            n_error_q8   = r_held_error;
        end

        if (r_line != r_confirmed) begin
            if (w_steady_inc >= r_confirm_count) begin
                n_confirmed = r_line;
                n_steady    = '0;
                n_flip      = 1'b1;
            end else begin
                n_steady = w_steady_inc;
            end
        end else begin
            n_steady = '0;
        end

        w_laps_after = (n_flip && r_lap_mode) ? r_laps + NCW'(1) : r_laps;
        n_laps       = w_laps_after;
        if (r_lap_mode && (w_laps_after >= r_lap_target)) begin
            n_lap_done = 1'b1;
            n_laps     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_error <= '0;
            r_lost_ticks <= '0;
            r_confirmed  <= 1'b0;
            r_steady     <= '0;
            r_laps       <= '0;
        end else if (i_cmd.commit) begin
            r_held_error <= n_held_error;
            r_lost_ticks <= n_lost_ticks;
            r_confirmed  <= n_confirmed;
            r_steady     <= n_steady;
            r_laps       <= n_laps;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_error_q8  <= n_error_q8;
            r_has_line  <= r_line;
            r_conf_line <= n_confirmed;
            r_flip      <= n_flip;
            r_lap_count <= n_laps;
            r_lap_done  <= n_lap_done;
        end
    end

    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_error_q8       = r_error_q8;
    assign o_has_line       = r_has_line;
    assign o_confirmed_line = r_conf_line;
    assign o_confirm_flip   = r_flip;
    assign o_lap_count      = r_lap_count;
    assign o_lap_done       = r_lap_done;

endmodule

// ===== rtl/line_track_error_debounce.sv =====
// ----------------------------------------------------------------------------
// line_track_error_debounce
// line follower track error with lost-line hold, debounce and lap counting
// ----------------------------------------------------------------------------
// Each input beat carries one tick of line sensor bits and yields exactly one
// result beat: the signed Q8.8 track error (mean of the configured weights of
// the active sensors, truncated toward zero, or the held / zeroed error while
// the line is lost), the raw and debounced line flags, a flip pulse, the lap
// count and a lap-done pulse. An item passes through the accept cycle, which
// forms the weighted sum and sensor count and loads the divider, then the
// restoring divider steps (18-bit dividend, three quotient bits a cycle), and
// then a commit that updates the tick state and loads the result register.
// The next beat is taken as soon as the commit is done, and not before, so
// only one item is in flight; the commit waits only while the previous result
// still sits unread in the output register. Configuration registers are to be
// written through the plain write port only while the block is idle; the
// block itself does not enforce this. There is no read-back.
// ----------------------------------------------------------------------------
module line_track_error_debounce #(
    parameter int NUM_SENSORS = ltd_pkg::NUM_SENSORS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [ltd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ltd_pkg::CFG_DATA_W-1:0] i_cfg_data,

    // sensor beats in, result beats out
    ltd_in_if.sink                         i_in,
    ltd_out_if.source                      o_out
);

    ltd_pkg::t_ltd_cmd w_cmd;
    ltd_pkg::t_ltd_sts w_sts;
    logic              w_in_ready;

    // sequencer: accept, divide, commit
    ltd_ctrl #(
        .DIV_ITERS (ltd_pkg::DIV_ITERS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // arithmetic, tick state and the output register
    ltd_dp #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_sensor_bits    (i_in.sensor_bits),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_error_q8       (o_out.error_q8),
        .o_has_line       (o_out.has_line),
        .o_confirmed_line (o_out.confirmed_line),
        .o_confirm_flip   (o_out.confirm_flip),
        .o_lap_count      (o_out.lap_count),
        .o_lap_done       (o_out.lap_done)
    );

    // ready only in idle, one item in flight at a time
    assign i_in.ready = w_in_ready;

endmodule
